@@ design/lnw_pkg.sv @@
`timescale 1ns / 1ps

package lnw_pkg;

  // Input operation codes
  localparam logic [1:0] OP_CMD    = 2'd0;
  localparam logic [1:0] OP_CHAR   = 2'd1;
  localparam logic [1:0] OP_NUM    = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;   // ignored: no writes, no state change

  // Configuration register indexes
  localparam logic REG_SPLIT = 1'b0;
  localparam logic REG_JUMP  = 1'b1;

  // Pause codes on the low nibble
  localparam logic [1:0] PAUSE_NONE  = 2'd0;
  localparam logic [1:0] PAUSE_SHORT = 2'd1;
  localparam logic [1:0] PAUSE_LONG  = 2'd2;

  localparam logic [7:0] SPLIT_RESET = 8'd8;
  localparam logic [7:0] JUMP_RESET  = 8'd168;   // 128 + 32 + 8
  localparam logic [7:0] CHAR_ZERO   = 8'h30;

  // Digit store depth; a 32-bit number needs ten decimal digits
  localparam int DIGIT_STORE   = 10;
  localparam int WORK_BITS     = 32;
  localparam int BIT_W         = $clog2(WORK_BITS);
  localparam int BCD_DIGITS    = 10;
  localparam int BCD_BITS      = BCD_DIGITS * 4;
  localparam int IDX_W         = $clog2(BCD_DIGITS);
  localparam int PRINT_DIGITS  = (DIGIT_STORE < BCD_DIGITS) ? DIGIT_STORE : BCD_DIGITS;

  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  // One byte to put on the bus
  typedef struct packed {
    logic       is_char;  // 1: data write, 0: command write
    logic [7:0] data;
    logic       last;     // final byte caused by its input transaction
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } push_t;

endpackage

@@ design/lnw_front.sv @@
`timescale 1ns / 1ps

module lnw_front import lnw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_value,
  input  logic        q_full,
  output logic        idle,
  output push_t       q_push
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CONV = 2'd1;
  localparam logic [1:0] F_SIZE = 2'd2;
  localparam logic [1:0] F_EMIT = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [WORK_BITS-1:0] work_r, work_nxt;
  logic [BCD_BITS-1:0]  digit_store_r, digit_store_nxt;
  logic [BIT_W-1:0]     bit_cnt_r, bit_cnt_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [BCD_BITS-1:0]  adj;
  logic [3:0]           digit;

  assign idle  = (state_r == F_IDLE);
  assign digit = digit_store_r[{idx_r, 2'b00} +: 4];

  // Double-dabble correction: bump each digit of five or more by three
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[i*4 +: 4] = (digit_store_r[i*4 +: 4] >= 4'd5) ?
                      digit_store_r[i*4 +: 4] + 4'd3 : digit_store_r[i*4 +: 4];
    end
  end

  always_comb begin
    logic [IDX_W-1:0] top;
    state_nxt       = state_r;
    work_nxt        = work_r;
    digit_store_nxt = digit_store_r;
    bit_cnt_nxt     = bit_cnt_r;
    idx_nxt         = idx_r;
    q_push          = '0;
    top             = '0;
    unique case (state_r)
      F_IDLE: begin
        if (in_fire) begin
          unique case (in_op)
            OP_CMD: begin
              q_push.push         = 1'b1;
              q_push.job.is_char  = 1'b0;
              q_push.job.data     = in_value[7:0];
              q_push.job.last     = 1'b1;
            end
            OP_CHAR: begin
              q_push.push         = 1'b1;
              q_push.job.is_char  = 1'b1;
              q_push.job.data     = in_value[7:0];
              q_push.job.last     = 1'b1;
            end
            OP_NUM: begin
              work_nxt        = in_value;
              digit_store_nxt = '0;
              bit_cnt_nxt     = '0;
              state_nxt       = F_CONV;
            end
            default: ;  // unused op: drop
          endcase
        end
      end
      F_CONV: begin
        digit_store_nxt = {adj[BCD_BITS-2:0], work_r[WORK_BITS-1]};
        work_nxt        = {work_r[WORK_BITS-2:0], 1'b0};
        bit_cnt_nxt     = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BIT_W'(WORK_BITS - 1)) begin
          state_nxt = F_SIZE;
        end
      end
      F_SIZE: begin
        // highest nonzero digit, capped at the store depth; zero prints one digit
        for (int i = 0; i < BCD_DIGITS; i++) begin
          if (digit_store_r[i*4 +: 4] != 4'd0) begin
            top = (i < PRINT_DIGITS) ? IDX_W'(i) : IDX_W'(PRINT_DIGITS - 1);
          end
        end
        idx_nxt   = top;
        state_nxt = F_EMIT;
      end
      F_EMIT: begin
        if (!q_full) begin
          q_push.push        = 1'b1;
          q_push.job.is_char = 1'b1;
          q_push.job.data    = CHAR_ZERO | {4'h0, digit};
          q_push.job.last    = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = F_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      work_r    <= '0;
      bit_cnt_r <= '0;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      work_r    <= work_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digit_store_r <= digit_store_nxt;
  end

endmodule

@@ design/lnw_queue.sv @@
`timescale 1ns / 1ps

module lnw_queue import lnw_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t q_push,
  input  logic  pop,
  output logic  full,
  output logic  empty,
  output job_t  head
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_push, do_pop;

  assign full    = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = q_push.push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= q_push.job;
  end

endmodule

@@ design/lnw_back.sv @@
`timescale 1ns / 1ps

module lnw_back import lnw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] split_column,
  input  logic [7:0] jump_command,
  input  logic       q_empty,
  input  job_t       q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       reg_select,
  output logic [3:0] nibble,
  output logic [1:0] pause,
  output logic       last
);

  localparam logic [2:0] B_EMPTY = 3'd0;
  localparam logic [2:0] B_HI    = 3'd1;
  localparam logic [2:0] B_LO    = 3'd2;
  localparam logic [2:0] B_JHI   = 3'd3;
  localparam logic [2:0] B_JLO   = 3'd4;

  logic [2:0] state_r, state_nxt;
  job_t       job_r;
  logic [7:0] char_count_r, char_count_nxt;
  logic [7:0] count_inc;
  logic       jump_hit, fire, finishing;

  assign count_inc = char_count_r + 8'd1;
  assign jump_hit  = job_r.is_char && (count_inc == split_column);
  assign fire      = out_valid && out_ready;
  assign finishing = fire && (((state_r == B_LO) && !jump_hit) || (state_r == B_JLO));
  assign q_pop     = !q_empty && ((state_r == B_EMPTY) || finishing);
  assign out_valid = (state_r != B_EMPTY);

  always_comb begin
    reg_select = 1'b0;
    nibble     = 4'h0;
    pause      = PAUSE_NONE;
    last       = 1'b0;
    unique case (state_r)
      B_HI: begin
        reg_select = job_r.is_char;
        nibble     = job_r.data[7:4];
      end
      B_LO: begin
        reg_select = job_r.is_char;
        nibble     = job_r.data[3:0];
        pause      = job_r.is_char ? PAUSE_SHORT : PAUSE_LONG;
        last       = job_r.last && !jump_hit;
      end
      B_JHI: begin
        nibble = jump_command[7:4];
      end
      B_JLO: begin
        nibble = jump_command[3:0];
        pause  = PAUSE_LONG;
        last   = job_r.last;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    char_count_nxt = char_count_r;
    if (fire) begin
      unique case (state_r)
        B_HI:  state_nxt = B_LO;
        B_LO: begin
          if (job_r.is_char) char_count_nxt = count_inc;
          state_nxt = jump_hit ? B_JHI : B_EMPTY;
        end
        B_JHI: state_nxt = B_JLO;
        default: state_nxt = B_EMPTY;
      endcase
    end
    if (q_pop) state_nxt = B_HI;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_EMPTY;
      char_count_r <= '0;
    end else begin
      state_r      <= state_nxt;
      char_count_r <= char_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_head;
  end

endmodule

@@ design/lcd_nibble_writer_with_decimal_print.sv @@
`timescale 1ns / 1ps
// Flow: a command or character is pushed to the queue in the cycle it is accepted; the back
//   end pops it and shows its high nibble; a number is converted and sized before its first digit.
// Throughput: one nibble per cycle on the bus side while out_tready is high, two per byte; a
//   number holds the input for its conversion (one bit per cycle), a sizing step and one
//   push per digit, longer while the queue is full.
// Reset: rst_n synchronous active low; clears control and char count, loads split
//   column 8 and jump command 168; queue contents and digit store are not cleared.
module lcd_nibble_writer_with_decimal_print import lnw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] op
  // nibble stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [3:0] nibble, [5:4] pause, [7:6] zero
  output logic        out_tuser,  // [0] reg_select
  output logic        out_tlast,
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0] split_column_r, jump_command_r;
  logic       in_fire, front_idle;
  logic       q_full, q_empty, q_pop;
  push_t      q_push;
  job_t       q_head;
  logic [3:0] nibble;
  logic [1:0] pause;

  // Front takes a transaction only from its idle state and only with room in
  // the queue, so a command or character is pushed the cycle it arrives.
  assign in_tready = front_idle && !q_full;
  assign in_fire   = in_tvalid && in_tready;

  // Hold config; software writes only while both sides are idle (not enforced here)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_column_r <= SPLIT_RESET;
      jump_command_r <= JUMP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SPLIT: split_column_r <= cfg_wdata;
        REG_JUMP:  jump_command_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Classify the transaction; convert numbers to digits, most significant first
  lnw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_op    (in_tuser),
    .in_value (in_tdata),
    .q_full   (q_full),
    .idle     (front_idle),
    .q_push   (q_push)
  );

  // Short byte queue decouples conversion from the slow bus side
  lnw_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (q_pop),
    .full   (q_full),
    .empty  (q_empty),
    .head   (q_head)
  );

  // Split bytes into nibbles, count characters, insert the jump command
  lnw_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .split_column (split_column_r),
    .jump_command (jump_command_r),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .reg_select   (out_tuser),
    .nibble       (nibble),
    .pause        (pause),
    .last         (out_tlast)
  );

  assign out_tdata = {2'b00, pause, nibble};

endmodule

@@ design/lnw_checker.sv @@
`timescale 1ns / 1ps

module lnw_checker import lnw_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  // A stalled nibble holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled nibble changed");

  // A high nibble is followed at once by its low nibble
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata[5:4] == PAUSE_NONE
    |=> out_tvalid && out_tdata[5:4] != PAUSE_NONE && out_tuser == $past(out_tuser))
    else $error("high nibble not followed by low nibble");

  // The final nibble of a transaction is always a low nibble
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[5:4] != PAUSE_NONE)
    else $error("last on a high nibble");

  // Short pause only after data, long pause only after a command; padding stays zero
  a_pause: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5:4] != PAUSE_SHORT || out_tuser) &&
                   (out_tdata[5:4] != PAUSE_LONG || !out_tuser) && out_tdata[7:6] == 2'b00)
    else $error("pause does not match register select");

endmodule

bind lcd_nibble_writer_with_decimal_print lnw_checker u_lnw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
